@@ design/ssm_pkg.sv @@
// Package for the shift-and string matcher: widths, item codes and the
// pipeline records shared by the datapath modules.
// No dependencies.
package ssm_pkg;

  localparam int MAX_PATTERN   = 63;
  localparam int POSITION_BITS = 32;
  localparam int BYTE_W        = 8;
  localparam int INDEX_W       = 6;
  localparam int LEN_W         = 6;
  localparam int FIELD_W       = 32;
  localparam int MASK_ROWS     = 256;
  localparam int CLR_W         = 9;

  typedef enum logic [1:0] {
    FUNC_LOAD    = 2'd0,
    FUNC_TEXT    = 2'd1,
    FUNC_RESTART = 2'd2
  } func_t;

  typedef struct packed {
    logic               valid;
    logic [1:0]         func;
    logic [BYTE_W-1:0]  data_byte;
    logic [INDEX_W-1:0] pattern_index;
  } stage_t;

  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] row;
    logic              set;
  } fwd_t;

endpackage

@@ design/ssm_if.sv @@
// Channel interfaces of the shift-and string matcher: input items,
// result items and the pattern length write channel.
// Depends on ssm_pkg.
interface ssm_in_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  func;
  logic [ssm_pkg::BYTE_W-1:0]  data_byte;
  logic [ssm_pkg::INDEX_W-1:0] pattern_index;

  modport source (output valid, output func, output data_byte, output pattern_index,
                  input ready);
  modport sink (input valid, input func, input data_byte, input pattern_index,
                output ready);
endinterface

interface ssm_out_if;
  logic                        valid;
  logic                        ready;
  logic                        match;
  logic [ssm_pkg::FIELD_W-1:0] match_start;
  logic [ssm_pkg::FIELD_W-1:0] match_total;

  modport source (output valid, output match, output match_start, output match_total,
                  input ready);
  modport sink (input valid, input match, input match_start, input match_total,
                output ready);
endinterface

interface ssm_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [ssm_pkg::LEN_W-1:0] pattern_length;

  modport source (output valid, output pattern_length, input ready);
  modport sink (input valid, input pattern_length, output ready);
endinterface

@@ design/ssm_ram.sv @@
// Synchronous single-port-write, single-port-read memory with bit write
// enables and a registered read. No dependencies.
module ssm_ram #(
  parameter int Depth = 256,
  parameter int Width = 8,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [AddrW-1:0]             waddr,
  input  logic [Width-1:0]             wbe,
  input  logic [Width-1:0]             wdata,
  input  logic                         re,
  input  logic [AddrW-1:0]             raddr,
  output logic [Width-1:0]             rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      for (int b = 0; b < Width; b++) begin
        if (wbe[b]) begin
          mem[waddr][b] <= wdata[b];
        end
      end
    end
  end

endmodule

@@ design/ssm_mask_ctrl.sv @@
// Mask table write control: clearing sweep after reset, the two writes of
// a pattern load (drop old byte's bit, set new byte's bit), last-write record.
// Depends on ssm_pkg.
module ssm_mask_ctrl #(
  parameter int MaxPattern = ssm_pkg::MAX_PATTERN
) (
  input  logic                       clk,
  input  logic                       rst,
  input  ssm_pkg::stage_t            s1,
  input  logic [ssm_pkg::BYTE_W-1:0] old_byte,
  output logic                       clearing,
  output logic                       mask_we,
  output logic [ssm_pkg::BYTE_W-1:0] mask_waddr,
  output logic [MaxPattern-1:0]      mask_wbe,
  output logic [MaxPattern-1:0]      mask_wdata,
  output ssm_pkg::fwd_t              fw,
  output logic [MaxPattern-1:0]      fw_bem
);
  localparam int IdxExtW = ssm_pkg::INDEX_W + 1;

  logic                        load_ok;
  logic                        s2_valid;
  logic [ssm_pkg::BYTE_W-1:0]  s2_byte;
  logic [ssm_pkg::INDEX_W-1:0] s2_idx;
  logic [ssm_pkg::INDEX_W-1:0] idx_sel;
  logic [MaxPattern-1:0]       onehot;
  logic [ssm_pkg::CLR_W-1:0]   clr_cnt;
  logic                        wr_set;

  assign load_ok = s1.valid && (s1.func == ssm_pkg::FUNC_LOAD) &&
                   ({1'b0, s1.pattern_index} < IdxExtW'(MaxPattern));
  assign clearing = !clr_cnt[ssm_pkg::CLR_W-1];
  assign idx_sel = load_ok ? s1.pattern_index : s2_idx;

  for (genvar i = 0; i < MaxPattern; i++) begin : g_lane
    assign onehot[i] = (ssm_pkg::INDEX_W'(i) == idx_sel);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt  <= '0;
      s2_valid <= 1'b0;
    end else begin
      if (clearing) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      s2_valid <= load_ok;
    end
  end

  always_ff @(posedge clk) begin
    s2_byte <= s1.data_byte;
    s2_idx  <= s1.pattern_index;
  end

  always_comb begin
    mask_we    = 1'b0;
    mask_waddr = clr_cnt[ssm_pkg::BYTE_W-1:0];
    mask_wbe   = '1;
    wr_set     = 1'b0;
    if (clearing) begin
      mask_we = 1'b1;
    end else if (load_ok) begin
      mask_we    = 1'b1;
      mask_waddr = old_byte;
      mask_wbe   = onehot;
    end else if (s2_valid) begin
      mask_we    = 1'b1;
      mask_waddr = s2_byte;
      mask_wbe   = onehot;
      wr_set     = 1'b1;
    end
    mask_wdata = wr_set ? mask_wbe : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fw.valid <= 1'b0;
    end else if (mask_we) begin
      fw.valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mask_we) begin
      fw.row <= mask_waddr;
      fw.set <= wr_set;
      fw_bem <= mask_wbe;
    end
  end

  a_load_writes_apart: assert property (@(posedge clk) disable iff (rst)
    s2_valid |-> !load_ok)
    else $error("pattern load writes overlap on the mask port");

  a_no_item_in_sweep: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s1.valid)
    else $error("item in flight during mask clearing sweep");

endmodule

@@ design/ssm_match_core.sv @@
// Match datapath: patches the mask row with the last table write, runs the
// shift-and update, tracks position and count, holds the result register.
// Depends on ssm_pkg.
module ssm_match_core #(
  parameter int MaxPattern   = ssm_pkg::MAX_PATTERN,
  parameter int PositionBits = ssm_pkg::POSITION_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  ssm_pkg::stage_t             s1,
  input  logic [MaxPattern-1:0]       mask_row,
  input  ssm_pkg::fwd_t               fw,
  input  logic [MaxPattern-1:0]       fw_bem,
  input  logic [ssm_pkg::LEN_W-1:0]   pattern_length,
  input  logic                        out_ready,
  output logic                        stall,
  output logic                        out_valid,
  output logic                        match,
  output logic [ssm_pkg::FIELD_W-1:0] match_start,
  output logic [ssm_pkg::FIELD_W-1:0] match_total
);
  localparam int UsedW  = ssm_pkg::LEN_W + 1;
  localparam int FieldW = ssm_pkg::FIELD_W;

  logic                    text, restart, adv, hit;
  logic [MaxPattern-1:0]   row, vec, vec_shift, vec_next, lane_en, lane_top;
  logic [UsedW-1:0]        used;
  logic [PositionBits-1:0] pos, back, start;
  logic [FieldW-1:0]       cnt, cnt_inc;

  assign text    = s1.valid && (s1.func == ssm_pkg::FUNC_TEXT);
  assign restart = s1.valid && (s1.func == ssm_pkg::FUNC_RESTART);
  assign stall   = text && out_valid && !out_ready;
  assign adv     = text && !stall;

  always_comb begin
    row = mask_row;
    if (fw.valid && (fw.row == s1.data_byte)) begin
      if (fw.set) begin
        row = mask_row | fw_bem;
      end else begin
        row = mask_row & ~fw_bem;
      end
    end
  end

  always_comb begin
    used = {1'b0, pattern_length};
    if (used == '0) begin
      used = UsedW'(1);
    end
    if (used > UsedW'(MaxPattern)) begin
      used = UsedW'(MaxPattern);
    end
  end

  for (genvar i = 0; i < MaxPattern; i++) begin : g_lane
    assign lane_en[i]  = (UsedW'(i) < used);
    assign lane_top[i] = (UsedW'(i + 1) == used);
  end

  assign vec_shift = MaxPattern'({vec, 1'b1});
  assign vec_next  = vec_shift & row & lane_en;
  assign hit       = |(vec_next & lane_top);
  assign back      = PositionBits'(used) - 1'b1;
  assign start     = (pos >= back) ? (pos - back) : '0;
  assign cnt_inc   = (cnt != '1) ? (cnt + 1'b1) : cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      vec <= '0;
      pos <= '0;
      cnt <= '0;
    end else if (restart) begin
      vec <= '0;
      pos <= '0;
      cnt <= '0;
    end else if (adv) begin
      vec <= vec_next;
      if (hit) begin
        cnt <= cnt_inc;
      end
      if (pos != '1) begin
        pos <= pos + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      match       <= hit;
      match_start <= hit ? FieldW'(start) : '0;
      match_total <= hit ? cnt_inc : cnt;
    end
  end

endmodule

@@ design/shift_and_string_matcher.sv @@
// Shift-and string matcher: top level with the item stage, the mask table
// and pattern byte memories, and the configuration register.
// Depends on ssm_pkg, ssm_if, ssm_ram, ssm_mask_ctrl, ssm_match_core.
//
// Text bytes stream at one per cycle unless a stalled result or a load
// holds them off; each yields one result, via the item stage into the
// output register. The pattern lives as a 256-row mask table, one bit per
// pattern position, read once per text byte. A load item holds off the
// next item, since its two updates of that table (drop the old byte's bit,
// set the new byte's bit) share the single write port. After reset a
// clearing pass sweeps all 256 rows of the mask table; items are held off
// during it while pattern_length writes are taken.
module shift_and_string_matcher #(
  parameter int MaxPattern   = ssm_pkg::MAX_PATTERN,
  parameter int PositionBits = ssm_pkg::POSITION_BITS
) (
  input logic       clk,
  input logic       rst,
  ssm_in_if.sink    text_in,
  ssm_out_if.source result_out,
  ssm_cfg_if.sink   cfg
);
  localparam int IdxW    = (MaxPattern > 1) ? $clog2(MaxPattern) : 1;
  localparam int IdxExtW = ssm_pkg::INDEX_W + 1;

  ssm_pkg::stage_t            s1;
  ssm_pkg::fwd_t              fw;
  logic [MaxPattern-1:0]      fw_bem;
  logic [MaxPattern-1:0]      mask_row, mask_wbe, mask_wdata;
  logic [ssm_pkg::BYTE_W-1:0] mask_waddr, old_byte;
  logic                       mask_we, clearing, stall, accept, load_acc, text_acc;
  logic                       load_in_range;
  logic [ssm_pkg::LEN_W-1:0]  pattern_length;

  assign cfg.ready     = 1'b1;
  assign text_in.ready = !clearing && !stall &&
                         !(s1.valid && (s1.func == ssm_pkg::FUNC_LOAD));
  assign accept        = text_in.valid && text_in.ready;
  assign load_acc      = accept && (text_in.func == ssm_pkg::FUNC_LOAD);
  assign text_acc      = accept && (text_in.func == ssm_pkg::FUNC_TEXT);
  assign load_in_range = ({1'b0, text_in.pattern_index} < IdxExtW'(MaxPattern));

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= ssm_pkg::LEN_W'(1);
    end else if (cfg.valid) begin
      pattern_length <= cfg.pattern_length;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
    end else if (accept) begin
      s1.valid <= 1'b1;
    end else if (!stall) begin
      s1.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1.func          <= text_in.func;
      s1.data_byte     <= text_in.data_byte;
      s1.pattern_index <= text_in.pattern_index;
    end
  end

  ssm_ram #(
    .Depth (MaxPattern),
    .Width (ssm_pkg::BYTE_W)
  ) u_pattern_ram (
    .clk   (clk),
    .we    (load_acc && load_in_range),
    .waddr (IdxW'(text_in.pattern_index)),
    .wbe   ({ssm_pkg::BYTE_W{1'b1}}),
    .wdata (text_in.data_byte),
    .re    (load_acc),
    .raddr (IdxW'(text_in.pattern_index)),
    .rdata (old_byte)
  );

  ssm_ram #(
    .Depth (ssm_pkg::MASK_ROWS),
    .Width (MaxPattern)
  ) u_mask_ram (
    .clk   (clk),
    .we    (mask_we),
    .waddr (mask_waddr),
    .wbe   (mask_wbe),
    .wdata (mask_wdata),
    .re    (text_acc),
    .raddr (text_in.data_byte),
    .rdata (mask_row)
  );

  ssm_mask_ctrl #(
    .MaxPattern (MaxPattern)
  ) u_mask_ctrl (
    .clk        (clk),
    .rst        (rst),
    .s1         (s1),
    .old_byte   (old_byte),
    .clearing   (clearing),
    .mask_we    (mask_we),
    .mask_waddr (mask_waddr),
    .mask_wbe   (mask_wbe),
    .mask_wdata (mask_wdata),
    .fw         (fw),
    .fw_bem     (fw_bem)
  );

  ssm_match_core #(
    .MaxPattern   (MaxPattern),
    .PositionBits (PositionBits)
  ) u_match_core (
    .clk            (clk),
    .rst            (rst),
    .s1             (s1),
    .mask_row       (mask_row),
    .fw             (fw),
    .fw_bem         (fw_bem),
    .pattern_length (pattern_length),
    .out_ready      (result_out.ready),
    .stall          (stall),
    .out_valid      (result_out.valid),
    .match          (result_out.match),
    .match_start    (result_out.match_start),
    .match_total    (result_out.match_total)
  );

  a_load_blocks_next: assert property (@(posedge clk) disable iff (rst)
    load_acc |=> !text_in.ready)
    else $error("item accepted while a pattern load holds the mask port");

  a_result_from_text: assert property (@(posedge clk) disable iff (rst)
    $rose(result_out.valid) |-> $past(s1.valid && (s1.func == ssm_pkg::FUNC_TEXT)))
    else $error("result raised without a text byte in the match stage");

  a_match_counted: assert property (@(posedge clk) disable iff (rst)
    (result_out.valid && result_out.match) |-> (result_out.match_total != '0))
    else $error("match reported with a zero match total");

endmodule

@@ tb/sv/tb_shift_and_string_matcher.sv @@
`timescale 1ns / 100ps
// Testbench for the shift-and string matcher: sends pattern loads, text bytes
// and restarts, predicts each result in order and checks it field by field.
// Depends on ssm_pkg, the ssm_if channel interfaces and the matcher RTL.
module tb_shift_and_string_matcher;

  localparam int BYTE_W        = ssm_pkg::BYTE_W;
  localparam int INDEX_W       = ssm_pkg::INDEX_W;
  localparam int LEN_W         = ssm_pkg::LEN_W;
  localparam int FIELD_W       = ssm_pkg::FIELD_W;
  localparam int MAX_PATTERN   = ssm_pkg::MAX_PATTERN;
  localparam int POSITION_BITS = ssm_pkg::POSITION_BITS;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 8;
  localparam int STALL_LIMIT = 4000;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic               match;
    logic [FIELD_W-1:0] start;
    logic [FIELD_W-1:0] total;
  } match_result_t;

  logic clk;
  logic rst;

  ssm_in_if  text_ch ();
  ssm_out_if result_ch ();
  ssm_cfg_if length_ch ();

  shift_and_string_matcher DUT (
    .clk        (clk),
    .rst        (rst),
    .text_in    (text_ch),
    .result_out (result_ch),
    .cfg        (length_ch)
  );

  logic [BYTE_W-1:0]        model_pattern [MAX_PATTERN];
  logic [MAX_PATTERN-1:0]   model_vector;
  logic [POSITION_BITS-1:0] model_position;
  logic [FIELD_W-1:0]       model_count;
  logic [LEN_W-1:0]         model_length;
  match_result_t            expected_results [$];

  logic [BYTE_W-1:0] stim_pattern [MAX_PATTERN];
  int unsigned       stim_length;

  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int hold_request = 0;

  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned matches_seen = 0;
  int unsigned length_writes = 0;
  int unsigned mismatch_count = 0;
  int unsigned phase_count = 0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int unsigned used_len(logic [LEN_W-1:0] value);
    if (value == 0) return 1;
    if (value > MAX_PATTERN) return MAX_PATTERN;
    return value;
  endfunction

  function automatic void shift_and_step(logic [1:0] func, logic [BYTE_W-1:0] data,
                                         logic [INDEX_W-1:0] index);
    logic [MAX_PATTERN-1:0] compare;
    int unsigned len;
    match_result_t res;
    case (func)
      ssm_pkg::FUNC_LOAD: begin
        if (index < MAX_PATTERN) model_pattern[index] = data;
      end
      ssm_pkg::FUNC_RESTART: begin
        model_vector = '0;
        model_position = '0;
        model_count = '0;
      end
      ssm_pkg::FUNC_TEXT: begin
        len = used_len(model_length);
        compare = '0;
        for (int i = 0; i < len; i++) begin
          if (model_pattern[i] == data) compare[i] = 1'b1;
        end
        model_vector = ((model_vector << 1) | 1) & compare;
        res = '0;
        res.match = model_vector[len-1];
        if (res.match) begin
          if (model_count != '1) model_count++;
          if (model_position >= len - 1) res.start = model_position - (len - 1);
        end
        if (model_position != '1) model_position++;
        res.total = model_count;
        expected_results = {expected_results, res};
      end
      default: begin
      end
    endcase
  endfunction

  always @(posedge clk) begin : monitor
    match_result_t oldest;
    if (!rst) begin
      if (result_ch.valid && result_ch.ready) begin
        results_seen++;
        if (result_ch.match) matches_seen++;
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("unexpected result: match=%0b start=%0d total=%0d",
                     result_ch.match, result_ch.match_start, result_ch.match_total);
        end else begin
          oldest = expected_results.pop_front();
          if (oldest.match !== result_ch.match || oldest.start !== result_ch.match_start ||
              oldest.total !== result_ch.match_total) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
              $display("mismatch: expected match=%0b start=%0d total=%0d,",
                       oldest.match, oldest.start, oldest.total,
                       " got match=%0b start=%0d total=%0d",
                       result_ch.match, result_ch.match_start, result_ch.match_total);
          end
        end
      end
      if (length_ch.valid && length_ch.ready) begin
        model_length = length_ch.pattern_length;
        length_writes++;
      end
      if (text_ch.valid && text_ch.ready)
        shift_and_step(text_ch.func, text_ch.data_byte, text_ch.pattern_index);
    end
  end

  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        result_ch.ready <= 1'b0;
        repeat (hold_request) @(negedge clk);
        hold_request = 0;
      end
      result_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((text_ch.valid && text_ch.ready) || (result_ch.valid && result_ch.ready) ||
          (length_ch.valid && length_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("FAIL");
    $finish;
  end

  task automatic send_item(logic [1:0] func, logic [BYTE_W-1:0] data,
                           logic [INDEX_W-1:0] index);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      text_ch.valid <= 1'b0;
      @(negedge clk);
    end
    text_ch.valid <= 1'b1;
    text_ch.func <= func;
    text_ch.data_byte <= data;
    text_ch.pattern_index <= index;
    @(posedge clk);
    while (text_ch.ready !== 1'b1) @(posedge clk);
    items_sent++;
    if (func == ssm_pkg::FUNC_LOAD && index < MAX_PATTERN) stim_pattern[index] = data;
  endtask

  task automatic drain_results();
    @(negedge clk);
    text_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_length(logic [LEN_W-1:0] value);
    @(negedge clk);
    length_ch.valid <= 1'b1;
    length_ch.pattern_length <= value;
    @(posedge clk);
    while (length_ch.ready !== 1'b1) @(posedge clk);
    @(negedge clk);
    length_ch.valid <= 1'b0;
    stim_length = used_len(value);
  endtask

  task automatic test_directed();
    src_idle_pct = 0;
    sink_stall_pct = 0;
    send_item(ssm_pkg::FUNC_LOAD, 8'h00, '0);
    send_item(ssm_pkg::FUNC_TEXT, 8'h00, '0);
    send_item(ssm_pkg::FUNC_TEXT, 8'hFF, '0);
    // drop: index past the store
    send_item(ssm_pkg::FUNC_LOAD, 8'hFF, INDEX_W'(MAX_PATTERN));
    send_item(ssm_pkg::FUNC_TEXT, 8'hFF, '0);
    send_item(FUNC_UNUSED, 8'hFF, INDEX_W'(MAX_PATTERN));
    send_item(ssm_pkg::FUNC_TEXT, 8'h00, '0);
    drain_results();
    write_length('0);
    send_item(ssm_pkg::FUNC_TEXT, 8'h00, '0);
    send_item(ssm_pkg::FUNC_LOAD, 8'hFF, INDEX_W'(1));
    send_item(ssm_pkg::FUNC_LOAD, 8'hFF, '0);
    drain_results();
    write_length(LEN_W'(2));
    repeat (3) send_item(ssm_pkg::FUNC_TEXT, 8'hFF, '0);
    send_item(ssm_pkg::FUNC_RESTART, 8'h00, '0);
    send_item(ssm_pkg::FUNC_TEXT, 8'hFF, '0);
    send_item(ssm_pkg::FUNC_TEXT, 8'hFF, '0);
    send_item(ssm_pkg::FUNC_LOAD, 8'h00, INDEX_W'(1));
    send_item(ssm_pkg::FUNC_TEXT, 8'h00, '0);
    drain_results();
  endtask

  task automatic test_random_traffic(int idle_pct, int stall_pct, int unsigned budget);
    logic [BYTE_W-1:0] alphabet [4];
    logic [LEN_W-1:0] length_value;
    int unsigned first_item;
    int unsigned phase_first;
    int unsigned phase_budget;
    int unsigned symbols;
    int unsigned pick;
    src_idle_pct = idle_pct;
    sink_stall_pct = stall_pct;
    first_item = items_sent;
    while (items_sent - first_item < budget) begin
      case (phase_count)
        0: length_value = LEN_W'(MAX_PATTERN);
        1: length_value = '0;
        2: length_value = LEN_W'(1);
        default: begin
          pick = $urandom_range(9);
          if (pick == 0) length_value = LEN_W'(MAX_PATTERN);
          else if (pick == 1) length_value = LEN_W'(1);
          else length_value = LEN_W'($urandom_range(2, 10));
        end
      endcase
      phase_count++;
      drain_results();
      write_length(length_value);
      foreach (alphabet[k]) alphabet[k] = BYTE_W'($urandom_range(255));
      symbols = $urandom_range(1, 4);
      phase_first = items_sent;
      phase_budget = $urandom_range(25, 60) + 2 * stim_length;
      for (int i = 0; i < stim_length; i++)
        send_item(ssm_pkg::FUNC_LOAD, alphabet[$urandom_range(symbols - 1)], INDEX_W'(i));
      while (items_sent - phase_first < phase_budget) begin
        pick = $urandom_range(99);
        if (pick < 25) begin
          for (int j = 0; j < stim_length; j++)
            send_item(ssm_pkg::FUNC_TEXT, stim_pattern[j], '0);
        end else if (pick < 85) begin
          send_item(ssm_pkg::FUNC_TEXT, alphabet[$urandom_range(symbols - 1)],
                    INDEX_W'($urandom_range(63)));
        end else if (pick < 89) begin
          send_item(ssm_pkg::FUNC_RESTART, BYTE_W'($urandom_range(255)),
                    INDEX_W'($urandom_range(63)));
        end else if (pick < 92) begin
          send_item(ssm_pkg::FUNC_LOAD, alphabet[$urandom_range(symbols - 1)],
                    INDEX_W'($urandom_range(stim_length - 1)));
        end else if (pick < 95) begin
          send_item(ssm_pkg::FUNC_LOAD, BYTE_W'($urandom_range(255)),
                    INDEX_W'(MAX_PATTERN));
        end else if (pick < 97) begin
          send_item(FUNC_UNUSED, BYTE_W'($urandom_range(255)),
                    INDEX_W'($urandom_range(63)));
        end else begin
          send_item(ssm_pkg::FUNC_TEXT, BYTE_W'($urandom_range(255)), '0);
        end
      end
    end
    drain_results();
  endtask

  task automatic test_backpressure();
    src_idle_pct = 0;
    sink_stall_pct = 0;
    drain_results();
    write_length(LEN_W'(3));
    for (int i = 0; i < 3; i++) send_item(ssm_pkg::FUNC_LOAD, 8'h5A, INDEX_W'(i));
    // hold the receiver off while the sender keeps streaming
    hold_request = 300;
    repeat (60) send_item(ssm_pkg::FUNC_TEXT, 8'h5A, '0);
    drain_results();
    repeat (10) send_item(ssm_pkg::FUNC_TEXT, $urandom_range(1) ? 8'h5A : 8'hA5, '0);
    drain_results();
    repeat (10) send_item(ssm_pkg::FUNC_TEXT, $urandom_range(1) ? 8'h5A : 8'hA5, '0);
    drain_results();
  endtask

  initial begin
    rst = 1'b1;
    text_ch.valid = 1'b0;
    text_ch.func = ssm_pkg::FUNC_LOAD;
    text_ch.data_byte = '0;
    text_ch.pattern_index = '0;
    length_ch.valid = 1'b0;
    length_ch.pattern_length = LEN_W'(1);
    model_vector = '0;
    model_position = '0;
    model_count = '0;
    model_length = LEN_W'(1);
    stim_length = 1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_random_traffic(0, 0, 160);
    test_random_traffic(86, 0, 160);
    test_random_traffic(0, 86, 160);
    test_random_traffic(16, 16, 160);
    test_backpressure();
    drain_results();

    $display("Sent %0d input transactions over %0d pattern length writes, lengths 0 to 63.",
             items_sent, length_writes);
    $display("Checked %0d results (%0d matches) under idle, stall and long hold phases.",
             results_seen, matches_seen);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ shift_and_string_matcher.f @@
design/ssm_pkg.sv
design/ssm_if.sv
design/ssm_ram.sv
design/ssm_mask_ctrl.sv
design/ssm_match_core.sv
design/shift_and_string_matcher.sv
tb/sv/tb_shift_and_string_matcher.sv
